[hdl/lcc_pkg.sv]
package lcc_pkg;

  localparam int MAX_HALF  = 3;
  localparam int NUM_TAPS  = 2 * MAX_HALF + 1;
  localparam int HALF_W    = 2;
  localparam int OFF_W     = $clog2(NUM_TAPS);
  localparam int LINE_MAX  = 4096;
  localparam int POS_W     = $clog2(LINE_MAX);
  localparam int SAMPLE_W  = 16;
  localparam int COEF_W    = 16;
  localparam int FRAC_W    = 14;
  localparam int PROD_W    = SAMPLE_W + COEF_W;
  localparam int SUM_W     = PROD_W + $clog2(NUM_TAPS);
  localparam int RND_W     = SUM_W - FRAC_W;
  localparam int NUM_PAIR  = (NUM_TAPS + 1) / 2;
  localparam int SAT_MAX   = 2 ** (SAMPLE_W - 1) - 1;
  localparam int SAT_MIN   = -(2 ** (SAMPLE_W - 1));
  localparam int Q_DEPTH   = 4;
  localparam int Q_PTR_W   = $clog2(Q_DEPTH);

  // register map
  localparam int NUM_CFG   = NUM_TAPS + 1;
  localparam int CFG_IDX_W = $clog2(NUM_CFG);
  localparam int CFG_HALF  = 0;
  localparam int CFG_COEF0 = 1;

  typedef logic [NUM_TAPS-1:0][SAMPLE_W-1:0] window_t;
  typedef logic [NUM_TAPS-1:0][COEF_W-1:0]   coef_arr_t;

  // unit gain on the center tap of the default 3-tap kernel
  localparam coef_arr_t COEF_RESET = coef_arr_t'(1 << (FRAC_W + COEF_W));
  localparam logic [HALF_W-1:0] HALF_RESET = HALF_W'(1);

  typedef enum logic [1:0] {
    KIND_NORMAL = 2'd0,
    KIND_FLUSH  = 2'd1,
    KIND_PASS   = 2'd2
  } kind_t;

  // one queued job: window snapshot plus what the back end needs to expand it
  typedef struct packed {
    kind_t             kind;
    logic [HALF_W-1:0] half;
    logic [HALF_W-1:0] d_start;
    logic [OFF_W-1:0]  pmax;
    window_t           win;
  } job_t;

endpackage

[hdl/line_convolution_clamped.sv]
// Pipeline: a result passes the queue, tap select, multiply, pair add, and
//   sum/round/saturate into the output register. Throughput: one sample per cycle
//   while the queue has room; a line-end sample yields min(h, p) + 1 back-end results
//   (one per cycle unless output stalls); the 4-entry job queue lets input keep going.
// Reset (synchronous, rst_n low) empties the queue and pipeline, returns to line start,
//   and loads half_width = 1, coef_1 = 1.0, all other taps 0.
module line_convolution_clamped (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [lcc_pkg::SAMPLE_W-1:0]   in_tdata,   // [15:0] in_sample
  input  logic                           in_tlast,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [lcc_pkg::SAMPLE_W-1:0]   out_tdata,  // [15:0] out_sample
  output logic                           out_tlast,
  input  logic                           cfg_we,
  input  logic [lcc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lcc_pkg::COEF_W-1:0]     cfg_wdata
);

  logic [lcc_pkg::HALF_W-1:0] half_r;
  lcc_pkg::coef_arr_t         coef_r;
  logic                       push, pop, q_valid, q_full;
  lcc_pkg::job_t              job_in, job_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r <= lcc_pkg::HALF_RESET;
      coef_r <= lcc_pkg::COEF_RESET;
    end else if (cfg_we) begin
      if (cfg_index == lcc_pkg::CFG_IDX_W'(lcc_pkg::CFG_HALF)) begin
        half_r <= cfg_wdata[lcc_pkg::HALF_W-1:0];
      end else begin
        coef_r[lcc_pkg::CFG_IDX_W'(cfg_index - lcc_pkg::CFG_IDX_W'(lcc_pkg::CFG_COEF0))]
          <= cfg_wdata;
      end
    end
  end

  lcc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_sample  (in_tdata),
    .in_last    (in_tlast),
    .half_width (half_r),
    .q_full     (q_full),
    .in_ready   (in_tready),
    .push       (push),
    .job        (job_in)
  );

  lcc_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .job_in  (job_in),
    .pop     (pop),
    .job_out (job_out),
    .q_valid (q_valid),
    .full    (q_full)
  );

  lcc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .job        (job_out),
    .coef       (coef_r),
    .pop        (pop),
    .out_valid  (out_tvalid),
    .out_sample (out_tdata),
    .out_last   (out_tlast),
    .out_ready  (out_tready)
  );

endmodule

[hdl/lcc_front.sv]
module lcc_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic [lcc_pkg::SAMPLE_W-1:0] in_sample,
  input  logic                         in_last,
  input  logic [lcc_pkg::HALF_W-1:0]   half_width,
  input  logic                         q_full,
  output logic                         in_ready,
  output logic                         push,
  output lcc_pkg::job_t                job
);

  logic [lcc_pkg::POS_W-1:0]  pos_r, pos_nxt;
  lcc_pkg::window_t           win_r, win_nxt;
  logic [lcc_pkg::HALF_W-1:0] h_eff;
  logic [lcc_pkg::HALF_W-1:0] d_first;
  logic                       accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && !q_full;
  assign win_nxt  = {win_r[lcc_pkg::NUM_TAPS-2:0], in_sample};

  always_comb begin
    if (32'(half_width) > lcc_pkg::MAX_HALF) h_eff = lcc_pkg::HALF_W'(lcc_pkg::MAX_HALF);
    else h_eff = half_width;
    if (pos_r < lcc_pkg::POS_W'(h_eff)) d_first = pos_r[lcc_pkg::HALF_W-1:0];
    else d_first = h_eff;
  end

  always_comb begin
    push        = 1'b0;
    job.kind    = lcc_pkg::KIND_NORMAL;
    job.half    = h_eff;
    job.d_start = h_eff;
    job.win     = win_nxt;
    if (pos_r > lcc_pkg::POS_W'(lcc_pkg::NUM_TAPS - 1)) begin
      job.pmax = lcc_pkg::OFF_W'(lcc_pkg::NUM_TAPS - 1);
    end else begin
      job.pmax = pos_r[lcc_pkg::OFF_W-1:0];
    end
    pos_nxt = pos_r;
    if (accept) begin
      if (!in_last) begin
        push = (pos_r >= lcc_pkg::POS_W'(h_eff));
        if (pos_r != lcc_pkg::POS_W'(lcc_pkg::LINE_MAX - 1)) pos_nxt = pos_r + 1'b1;
      end else begin
        push    = 1'b1;
        pos_nxt = '0;
        // a one-sample line goes out untouched
        if (pos_r == '0) job.kind = lcc_pkg::KIND_PASS;
        else begin
          job.kind    = lcc_pkg::KIND_FLUSH;
          job.d_start = d_first;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

  // older entries are never selected past the left clamp, so no reset
  always_ff @(posedge clk) begin
    if (accept) win_r <= win_nxt;
  end

endmodule

[hdl/lcc_queue.sv]
module lcc_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  lcc_pkg::job_t job_in,
  input  logic          pop,
  output lcc_pkg::job_t job_out,
  output logic          q_valid,
  output logic          full
);

  lcc_pkg::job_t              mem_r [lcc_pkg::Q_DEPTH];
  logic [lcc_pkg::Q_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [lcc_pkg::Q_PTR_W:0]   cnt_r;

  assign full    = (cnt_r == (lcc_pkg::Q_PTR_W + 1)'(lcc_pkg::Q_DEPTH));
  assign q_valid = (cnt_r != '0);
  assign job_out = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop) cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= job_in;
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (lcc_pkg::Q_PTR_W + 1)'(lcc_pkg::Q_DEPTH))
    else $error("queue count exceeds depth");
`endif

endmodule

[hdl/lcc_back.sv]
module lcc_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_valid,
  input  lcc_pkg::job_t                job,
  input  lcc_pkg::coef_arr_t           coef,
  output logic                         pop,
  output logic                         out_valid,
  output logic [lcc_pkg::SAMPLE_W-1:0] out_sample,
  output logic                         out_last,
  input  logic                         out_ready
);

  // flush expansion
  logic                       mid_r, mid_nxt;
  logic [lcc_pkg::HALF_W-1:0] d_r, d_nxt;
  logic [lcc_pkg::HALF_W-1:0] d_now;
  logic [lcc_pkg::OFF_W-1:0]  k;
  logic                       final_job, issue, job_last;
  lcc_pkg::window_t           tap_smp;

  // stage valids and advance enables
  logic s1_v_r, s2_v_r, s3_v_r, out_v_r;
  logic en1, en2, en3, en_o;

  logic                                 s1_pass_r, s1_last_r;
  logic [lcc_pkg::SAMPLE_W-1:0]         s1_byp_r;
  lcc_pkg::window_t                     s1_smp_r;
  logic                                 s2_pass_r, s2_last_r;
  logic [lcc_pkg::SAMPLE_W-1:0]         s2_byp_r;
  logic signed [lcc_pkg::PROD_W-1:0]    s2_prod_r [lcc_pkg::NUM_TAPS];
  logic                                 s3_pass_r, s3_last_r;
  logic [lcc_pkg::SAMPLE_W-1:0]         s3_byp_r;
  logic signed [lcc_pkg::SUM_W-1:0]     s3_ps_r [lcc_pkg::NUM_PAIR];
  logic signed [lcc_pkg::SUM_W-1:0]     ps [lcc_pkg::NUM_PAIR];
  logic signed [lcc_pkg::SUM_W-1:0]     total;
  logic signed [lcc_pkg::RND_W-1:0]     rnd;
  logic [lcc_pkg::SAMPLE_W-1:0]         sat_smp;
  logic [lcc_pkg::SAMPLE_W-1:0]         out_smp_r;
  logic                                 out_last_r;

  assign en_o = !out_v_r || out_ready;
  assign en3  = !s3_v_r || en_o;
  assign en2  = !s2_v_r || en3;
  assign en1  = !s1_v_r || en2;

  assign d_now     = mid_r ? d_r : job.d_start;
  assign final_job = (job.kind != lcc_pkg::KIND_FLUSH) || (d_now == '0);
  assign issue     = q_valid && en1;
  assign pop       = issue && final_job;
  assign job_last  = (job.kind == lcc_pkg::KIND_PASS) ||
                     ((job.kind == lcc_pkg::KIND_FLUSH) && (d_now == '0));

  always_comb begin
    mid_nxt = mid_r;
    d_nxt   = d_r;
    if (issue) begin
      if (final_job) mid_nxt = 1'b0;
      else begin
        mid_nxt = 1'b1;
        d_nxt   = d_now - 1'b1;
      end
    end
  end

  // tap i reads the sample d+h-i behind the newest, clamped to the line ends
  assign k = lcc_pkg::OFF_W'(d_now) + lcc_pkg::OFF_W'(job.half);

  always_comb begin
    logic [lcc_pkg::OFF_W-1:0] sel;
    for (int i = 0; i < lcc_pkg::NUM_TAPS; i++) begin
      if (lcc_pkg::OFF_W'(i) > k) sel = '0;
      else sel = k - lcc_pkg::OFF_W'(i);
      if (sel > job.pmax) sel = job.pmax;
      if (lcc_pkg::OFF_W'(i) <= lcc_pkg::OFF_W'({job.half, 1'b0})) tap_smp[i] = job.win[sel];
      else tap_smp[i] = '0;
    end
  end

  for (genvar j = 0; j < lcc_pkg::NUM_PAIR; j++) begin : g_pair
    if (2 * j + 1 < lcc_pkg::NUM_TAPS) begin : g_two
      assign ps[j] = lcc_pkg::SUM_W'(s2_prod_r[2*j]) + lcc_pkg::SUM_W'(s2_prod_r[2*j+1]);
    end else begin : g_one
      assign ps[j] = lcc_pkg::SUM_W'(s2_prod_r[2*j]);
    end
  end

  // round half up, then saturate
  always_comb begin
    total = lcc_pkg::SUM_W'(1 << (lcc_pkg::FRAC_W - 1));
    for (int j = 0; j < lcc_pkg::NUM_PAIR; j++) begin
      total = total + s3_ps_r[j];
    end
    rnd = total[lcc_pkg::SUM_W-1:lcc_pkg::FRAC_W];
    if (rnd > lcc_pkg::RND_W'(lcc_pkg::SAT_MAX)) begin
      sat_smp = lcc_pkg::SAMPLE_W'(lcc_pkg::SAT_MAX);
    end else if (rnd < lcc_pkg::RND_W'(lcc_pkg::SAT_MIN)) begin
      sat_smp = lcc_pkg::SAMPLE_W'(lcc_pkg::SAT_MIN);
    end else begin
      sat_smp = rnd[lcc_pkg::SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_r   <= 1'b0;
      d_r     <= '0;
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      mid_r <= mid_nxt;
      d_r   <= d_nxt;
      if (en1) s1_v_r <= issue;
      if (en2) s2_v_r <= s1_v_r;
      if (en3) s3_v_r <= s2_v_r;
      if (en_o) out_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_smp_r  <= tap_smp;
      s1_pass_r <= (job.kind == lcc_pkg::KIND_PASS);
      s1_last_r <= job_last;
      s1_byp_r  <= job.win[0];
    end
    if (en2) begin
      for (int i = 0; i < lcc_pkg::NUM_TAPS; i++) begin
        s2_prod_r[i] <= $signed(s1_smp_r[i]) * $signed(coef[i]);
      end
      s2_pass_r <= s1_pass_r;
      s2_last_r <= s1_last_r;
      s2_byp_r  <= s1_byp_r;
    end
    if (en3) begin
      for (int j = 0; j < lcc_pkg::NUM_PAIR; j++) begin
        s3_ps_r[j] <= ps[j];
      end
      s3_pass_r <= s2_pass_r;
      s3_last_r <= s2_last_r;
      s3_byp_r  <= s2_byp_r;
    end
    if (en_o) begin
      out_smp_r  <= s3_pass_r ? s3_byp_r : sat_smp;
      out_last_r <= s3_last_r;
    end
  end

  assign out_valid  = out_v_r;
  assign out_sample = out_smp_r;
  assign out_last   = out_last_r;

`ifndef SYNTHESIS
  a_mid_has_job: assert property (@(posedge clk) disable iff (!rst_n)
    mid_r |-> q_valid)
    else $error("flush expansion lost its queued job");

  a_mid_is_flush: assert property (@(posedge clk) disable iff (!rst_n)
    (issue && mid_r) |-> (job.kind == lcc_pkg::KIND_FLUSH))
    else $error("expansion running on a non-flush job");

  a_pass_last: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && s1_pass_r) |-> s1_last_r)
    else $error("pass-through result not marked last");
`endif

endmodule
